[src/piecewise_poly_pose_eval_assert.svh]
// Assertion macros shared by the pose evaluator.
// Each macro expects clk and rst_n in scope.
`ifndef PIECEWISE_POLY_POSE_EVAL_ASSERT_SVH
`define PIECEWISE_POLY_POSE_EVAL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ppe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_pkg
// Types, constants and helper functions of the piecewise polynomial pose
// evaluator.
// ----------------------------------------------------------------------------
package ppe_pkg;

    // Horner accumulator width; holds the derivative sum up to degree 15.
    localparam int ACC_W        = 40;
    // Normalized segment time, 0..65536.
    localparam int U_W          = 17;
    // Span and offset of a segment, unsigned.
    localparam int SPAN_W       = 33;
    // CORDIC vector and angle widths.
    localparam int XW           = 44;
    localparam int ZW           = 28;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;
    localparam int NORM_BIT     = 37;
    localparam int HEAD_MAX     = 25736;
    localparam int PI_Q24       = 52707179;

    typedef enum logic [1:0] {
        OP_KNOT = 2'd0,
        OP_COEF = 2'd1,
        OP_EVAL = 2'd2
    } op_t;

    localparam logic [1:0] CFG_SEGMENTS = 2'd0;
    localparam logic [1:0] CFG_DEGREE   = 2'd1;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Saturate an accumulator to a signed 32-bit result.
    function automatic logic signed [31:0] sat32(input acc_t v);
        logic signed [31:0] r;
        if (v > acc_t'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < acc_t'(-64'sd2147483648)) begin
            r = 32'sh80000000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Arctangent of 2^-i in Q.24 radians.
    function automatic logic signed [ZW-1:0] atan_q24(input logic [STEP_W-1:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = 28'sd13176795;
            5'd1:    r = 28'sd7778716;
            5'd2:    r = 28'sd4110060;
            5'd3:    r = 28'sd2086331;
            5'd4:    r = 28'sd1047214;
            5'd5:    r = 28'sd524117;
            5'd6:    r = 28'sd262123;
            5'd7:    r = 28'sd131069;
            5'd8:    r = 28'sd65536;
            5'd9:    r = 28'sd32768;
            5'd10:   r = 28'sd16384;
            5'd11:   r = 28'sd8192;
            5'd12:   r = 28'sd4096;
            5'd13:   r = 28'sd2048;
            5'd14:   r = 28'sd1024;
            5'd15:   r = 28'sd512;
            5'd16:   r = 28'sd256;
            5'd17:   r = 28'sd128;
            5'd18:   r = 28'sd64;
            5'd19:   r = 28'sd32;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[src/ppe_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_div
// Restoring divider giving u = floor(num * 2^16 / den) for num <= den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppe_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ppe_pkg::SPAN_W-1:0]  num,
    input  logic [ppe_pkg::SPAN_W-1:0]  den,
    output logic                        done,
    output logic [ppe_pkg::U_W-1:0]     quot
);
    import ppe_pkg::*;

    localparam int CNT_W = $clog2(U_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SPAN_W:0]     rem_reg;
    logic [SPAN_W-1:0]   den_reg;
    logic [U_W-1:0]      quot_reg;
    logic [SPAN_W:0]     trial;
    logic [SPAN_W:0]     diff;
    logic                ge;

    // The first step tests the integer bit, the rest shift in zeros.
    always_comb
    begin
        trial = (cnt_reg == '0) ? rem_reg : {rem_reg[SPAN_W-1:0], 1'b0};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(U_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff : trial;
            quot_reg <= {quot_reg[U_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[src/ppe_head.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_head
// Heading unit: folds the left half-plane, normalizes the derivative vector
// one bit a cycle, runs a vectoring CORDIC and rounds to Q3.13 radians.
// ----------------------------------------------------------------------------
module ppe_head (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ppe_pkg::acc_t       dx,
    input  ppe_pkg::acc_t       dy,
    output logic                done,
    output logic signed [15:0]  heading
);
    import ppe_pkg::*;

    typedef enum logic [1:0] {
        H_IDLE,
        H_NORM,
        H_ROT,
        H_RND
    } hstate_t;

    localparam logic signed [XW-1:0] NORM_LIM = XW'(1) << NORM_BIT;

    hstate_t                 state_reg;
    logic                    done_reg;
    logic signed [15:0]      heading_reg;
    logic signed [XW-1:0]    x_reg;
    logic signed [XW-1:0]    y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic [STEP_W-1:0]       i_reg;

    logic signed [XW-1:0]    dx_ext;
    logic signed [XW-1:0]    dy_ext;
    logic signed [XW-1:0]    x_sh;
    logic signed [XW-1:0]    y_sh;
    logic                    small_vec;
    logic signed [ZW-1:0]    z_rnd;
    logic signed [ZW-12:0]   r_val;
    logic signed [15:0]      r_clamp;

    // Step terms, normalization test and final rounding.
    always_comb
    begin
        dx_ext    = XW'(dx);
        dy_ext    = XW'(dy);
        x_sh      = x_reg >>> i_reg;
        y_sh      = y_reg >>> i_reg;
        small_vec = (x_reg < NORM_LIM) && (y_reg < NORM_LIM) && (y_reg > -NORM_LIM);
        z_rnd     = z_reg + ZW'(1024);
        r_val     = z_rnd[ZW-1:11];
        if (r_val > (ZW-11)'(HEAD_MAX))
        begin
            r_clamp = 16'(HEAD_MAX);
        end
        else if (r_val < -((ZW-11)'(HEAD_MAX)))
        begin
            r_clamp = -16'(HEAD_MAX);
        end
        else
        begin
            r_clamp = r_val[15:0];
        end
    end

    // Sequencer with result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= H_IDLE;
            done_reg    <= 1'b0;
            heading_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        if (dx == '0 && dy == '0)
                        begin
                            heading_reg <= '0;
                            done_reg    <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= H_NORM;
                        end
                    end
                end
                H_NORM:
                begin
                    if (!small_vec)
                    begin
                        state_reg <= H_ROT;
                    end
                end
                H_ROT:
                begin
                    if (i_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= H_RND;
                    end
                end
                H_RND:
                begin
                    heading_reg <= r_clamp;
                    done_reg    <= 1'b1;
                    state_reg   <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    // Vector and angle datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            H_IDLE:
            begin
                i_reg <= '0;
                if (dx < 0)
                begin
                    x_reg <= -dx_ext;
                    y_reg <= -dy_ext;
                    z_reg <= (dy >= 0) ? ZW'(PI_Q24) : -ZW'(PI_Q24);
                end
                else
                begin
                    x_reg <= dx_ext;
                    y_reg <= dy_ext;
                    z_reg <= '0;
                end
            end
            H_NORM:
            begin
                if (small_vec)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            H_ROT:
            begin
                i_reg <= i_reg + 1'b1;
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_q24(i_reg);
                end
                else
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_q24(i_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done    = done_reg;
    assign heading = heading_reg;

endmodule

[src/piecewise_poly_pose_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_poly_pose_eval
// Piecewise polynomial pose evaluator: knot and coefficient stores in two
// synchronous memories, segment search, u division, Horner evaluation of
// x, y, z and the x/y derivatives, and a CORDIC heading.
// Load words are taken in the idle state. A query that finds no segment skips
// the divider, the Horner evaluation and the heading.
// One item at a time; the knot memory read per segment, the divider and
// the CORDIC loop set the query time. Reset clears control and the held pose;
// the memories are not cleared.
// ----------------------------------------------------------------------------
module piecewise_poly_pose_eval #(
    parameter int MAX_SEGMENTS = 16,
    parameter int MAX_DEGREE   = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    // Input words
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [6:0]          entry_index,
    input  logic [1:0]          axis,
    input  logic signed [31:0]  entry_value,
    input  logic [31:0]         query_time,
    // Result words
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pose_x,
    output logic signed [31:0]  pose_y,
    output logic signed [31:0]  pose_z,
    output logic signed [15:0]  heading,
    output logic                found,
    // Configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import ppe_pkg::*;

    localparam int NKNOT  = MAX_SEGMENTS + 1;
    localparam int STRIDE = MAX_DEGREE + 1;
    localparam int NCOEF  = MAX_SEGMENTS * STRIDE;
    localparam int KW     = $clog2(NKNOT);
    localparam int CW     = $clog2(NCOEF);
    localparam int PW     = $clog2(STRIDE);
    localparam int PROD_W = ACC_W + U_W + 1;
    localparam int DT_W   = PW + 33;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KSTART,
        S_KCMP,
        S_DIV,
        S_ERD,
        S_EMUL,
        S_EACC,
        S_HEAD,
        S_FIN
    } state_t;

    // Control and held state
    state_t              state_reg;
    logic [4:0]          segments_reg;
    logic [2:0]          degree_reg;
    logic                out_valid_reg;
    logic signed [31:0]  out_x_reg;
    logic signed [31:0]  out_y_reg;
    logic signed [31:0]  out_z_reg;
    logic signed [15:0]  out_head_reg;
    logic                out_found_reg;
    logic signed [31:0]  held_x_reg;
    logic signed [31:0]  held_y_reg;
    logic signed [31:0]  held_z_reg;
    logic signed [15:0]  held_head_reg;
    logic                found_reg;

    // Datapath
    logic [31:0]         t_reg;
    logic signed [31:0]  start_reg;
    logic [KW-1:0]       seg_reg;
    logic [CW-1:0]       base_reg;
    logic [PW-1:0]       p_reg;
    logic [U_W-1:0]      u_reg;
    acc_t                acc_reg [5];
    logic signed [PROD_W-1:0] prod_reg [5];

    // Memories
    logic signed [31:0]  knot_mem [NKNOT];
    logic signed [31:0]  knot_rd_reg;
    logic [2:0][31:0]    coef_mem [NCOEF];
    logic [2:0][31:0]    coef_rd_reg;

    logic                in_acc;
    logic                knot_re;
    logic [KW-1:0]       knot_raddr;
    logic                knot_we;
    logic                coef_we;
    logic [CW-1:0]       coef_raddr;
    logic [KW-1:0]       nseg_sel;
    logic [PW-1:0]       deg_sel;
    logic signed [33:0]  t_ext;
    logic signed [33:0]  s_ext;
    logic signed [33:0]  e_ext;
    logic signed [33:0]  span;
    logic signed [33:0]  offs;
    logic                hit;
    logic                more_seg;
    logic                first_pow;
    logic                div_start;
    logic                div_done;
    logic [U_W-1:0]      div_quot;
    logic                head_start;
    logic                head_done;
    logic signed [15:0]  head_val;
    logic                out_free;
    acc_t                lane_c [5];
    acc_t                lane_h [5];

    assign in_acc    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // Effective segment count and degree, saturated to the store.
    always_comb
    begin
        if (32'(segments_reg) > MAX_SEGMENTS)
        begin
            nseg_sel = KW'(MAX_SEGMENTS);
        end
        else
        begin
            nseg_sel = KW'(segments_reg);
        end
        if (32'(degree_reg) > MAX_DEGREE)
        begin
            deg_sel = PW'(MAX_DEGREE);
        end
        else
        begin
            deg_sel = PW'(degree_reg);
        end
    end

    // Segment compare on the knot just read.
    always_comb
    begin
        t_ext    = $signed({2'b00, t_reg});
        s_ext    = 34'(start_reg);
        e_ext    = 34'(knot_rd_reg);
        span     = e_ext - s_ext;
        offs     = t_ext - s_ext;
        hit      = (t_ext >= s_ext) && (t_ext <= e_ext);
        more_seg = (32'(seg_reg) + 1) < 32'(nseg_sel);
    end

    // Memory access control.
    always_comb
    begin
        knot_we    = in_acc && (operation == OP_KNOT) && (32'(entry_index) < NKNOT);
        coef_we    = in_acc && (operation == OP_COEF) && (32'(entry_index) < NCOEF)
                     && (axis != 2'd3);
        knot_re    = 1'b0;
        knot_raddr = '0;
        if (in_acc && operation == OP_EVAL)
        begin
            knot_re = 1'b1;
        end
        else if (state_reg == S_KSTART)
        begin
            knot_re    = 1'b1;
            knot_raddr = seg_reg + 1'b1;
        end
        else if (state_reg == S_KCMP)
        begin
            knot_re    = 1'b1;
            knot_raddr = seg_reg + KW'(2);
        end
        coef_raddr = base_reg + CW'(p_reg);
        div_start  = (state_reg == S_KCMP) && hit && (span != '0);
        head_start = (state_reg == S_EACC) && (p_reg == '0);
        first_pow  = (p_reg == deg_sel);
    end

    // Knot store.
    always_ff @(posedge clk)
    begin
        if (knot_we)
        begin
            knot_mem[KW'(entry_index)] <= entry_value;
        end
        if (knot_re)
        begin
            knot_rd_reg <= knot_mem[knot_raddr];
        end
    end

    // Coefficient store, one 32-bit lane per axis.
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[CW'(entry_index)][axis] <= entry_value;
        end
        if (state_reg == S_ERD)
        begin
            coef_rd_reg <= coef_mem[coef_raddr];
        end
    end

    // Lane terms: positions add c, derivatives add p*c.
    always_comb
    begin
        logic signed [DT_W-1:0] dt;
        dt = '0;
        for (int k = 0; k < 5; k++)
        begin
            if (k < 3)
            begin
                lane_c[k] = ACC_W'($signed(coef_rd_reg[k]));
            end
            else
            begin
                dt        = $signed({1'b0, p_reg}) * $signed(coef_rd_reg[k-3]);
                lane_c[k] = ACC_W'(dt);
            end
            lane_h[k] = $signed(prod_reg[k][ACC_W+15:16]);
        end
    end

    ppe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (offs[SPAN_W-1:0]),
        .den   (span[SPAN_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    ppe_head u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (head_start),
        .dx      (acc_reg[3]),
        .dy      (acc_reg[4]),
        .done    (head_done),
        .heading (head_val)
    );

    // Query sequencer, configuration, held pose and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            segments_reg  <= 5'd1;
            degree_reg    <= 3'd7;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_head_reg  <= '0;
            out_found_reg <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            held_z_reg    <= '0;
            held_head_reg <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SEGMENTS)
                begin
                    segments_reg <= cfg_data[4:0];
                end
                else if (cfg_index == CFG_DEGREE)
                begin
                    degree_reg <= cfg_data[2:0];
                end
            end
            // A word leaving while the next one loads is handled in S_FIN.
            if (out_valid_reg && out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && operation == OP_EVAL)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= (nseg_sel == '0) ? S_FIN : S_KSTART;
                    end
                end
                S_KSTART:
                begin
                    state_reg <= S_KCMP;
                end
                S_KCMP:
                begin
                    if (hit)
                    begin
                        state_reg <= (span == '0) ? S_ERD : S_DIV;
                    end
                    else if (!more_seg)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_ERD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EMUL;
                end
                S_EMUL:
                begin
                    state_reg <= S_EACC;
                end
                S_EACC:
                begin
                    state_reg <= (p_reg == '0) ? S_HEAD : S_ERD;
                end
                S_HEAD:
                begin
                    if (head_done)
                    begin
                        held_x_reg    <= sat32(acc_reg[0]);
                        held_y_reg    <= sat32(acc_reg[1]);
                        held_z_reg    <= sat32(acc_reg[2]);
                        held_head_reg <= head_val;
                        found_reg     <= 1'b1;
                        state_reg     <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= held_x_reg;
                        out_y_reg     <= held_y_reg;
                        out_z_reg     <= held_z_reg;
                        out_head_reg  <= held_head_reg;
                        out_found_reg <= found_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Search and Horner datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                t_reg    <= query_time;
                seg_reg  <= '0;
                base_reg <= '0;
            end
            S_KSTART:
            begin
                start_reg <= knot_rd_reg;
            end
            S_KCMP:
            begin
                p_reg <= deg_sel;
                u_reg <= '0;
                // Derivatives start at zero so a constant polynomial gives none.
                acc_reg[3] <= '0;
                acc_reg[4] <= '0;
                if (!hit)
                begin
                    start_reg <= knot_rd_reg;
                    seg_reg   <= seg_reg + 1'b1;
                    base_reg  <= base_reg + CW'(STRIDE);
                end
            end
            S_DIV:
            begin
                u_reg <= div_quot;
            end
            S_EMUL:
            begin
                for (int k = 0; k < 5; k++)
                begin
                    prod_reg[k] <= acc_reg[k] * $signed({1'b0, u_reg});
                end
            end
            S_EACC:
            begin
                p_reg <= p_reg - 1'b1;
                for (int k = 0; k < 5; k++)
                begin
                    if (first_pow)
                    begin
                        acc_reg[k] <= lane_c[k];
                    end
                    else if (k < 3 || p_reg != '0)
                    begin
                        acc_reg[k] <= lane_h[k] + lane_c[k];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pose_x    = out_x_reg;
    assign pose_y    = out_y_reg;
    assign pose_z    = out_z_reg;
    assign heading   = out_head_reg;
    assign found     = out_found_reg;

    `include "piecewise_poly_pose_eval_assert.svh"

    `PPE_ASSERT_NXT(a_eval_blocks_input, in_acc && operation == OP_EVAL, !in_ready, "query did not block input")
    `PPE_ASSERT_IMP(a_div_in_state, div_done, state_reg == S_DIV, "divider done outside wait")
    `PPE_ASSERT_IMP(a_head_in_state, head_done, state_reg == S_HEAD, "heading done outside wait")
    `PPE_ASSERT_IMP(a_heading_range, out_valid, (heading <= 16'sd25736) && (heading >= -16'sd25736), "heading out of range")

endmodule

[tb/sv/ppe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_checker
// Watches the input, result and configuration channels of the pose
// evaluator, keeps its own copy of the knot and coefficient stores, the
// held pose and the two registers, predicts the pose word of every
// evaluate word and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module ppe_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [6:0]         entry_index,
    input  logic [1:0]         axis,
    input  logic signed [31:0] entry_value,
    input  logic [31:0]        query_time,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic signed [31:0] pose_z,
    input  logic signed [15:0] heading,
    input  logic               found,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import ppe_pkg::*;

    localparam int SEGS     = 16;
    localparam int DEG_MAX  = 7;
    localparam int KNOTS    = SEGS + 1;
    localparam int AX_X     = 0;
    localparam int AX_Y     = 1;
    localparam int AX_Z     = 2;
    localparam int DEPTH    = 16;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] hd;
        logic               fnd;
    } pose_word_t;

    // Arctangent of 2^-i in Q.24 radians.
    localparam longint ARCTAN [20] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    logic signed [31:0] knot_store [KNOTS];
    logic signed [31:0] coef_store [3][SEGS*(DEG_MAX+1)];
    logic [4:0]         seg_reg;
    logic [2:0]         deg_reg;
    pose_word_t         held_pose;
    pose_word_t         expected_poses [DEPTH];
    int                 wr_count;
    int                 rd_count;
    int                 mismatches;

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Horner evaluation of one axis position at normalized time u.
    function automatic longint position_at(input int ax, input int base, input int deg,
                                           input longint u);
        longint acc;
        acc = coef_store[ax][base+deg];
        for (int d = deg - 1; d >= 0; d--) begin
            acc = ((acc * u) >>> 16) + longint'(coef_store[ax][base+d]);
        end
        return acc;
    endfunction

    // Horner evaluation of the derivative with respect to u.
    function automatic longint slope_at(input int ax, input int base, input int deg,
                                        input longint u);
        longint acc;
        if (deg == 0) return 0;
        acc = longint'(deg) * coef_store[ax][base+deg];
        for (int d = deg - 1; d >= 1; d--) begin
            acc = ((acc * u) >>> 16) + longint'(d) * coef_store[ax][base+d];
        end
        return acc;
    endfunction

    // Vectoring CORDIC for atan2(dy, dx), rounded to Q3.13 and clamped.
    function automatic logic signed [15:0] yaw_of(input longint dx, input longint dy);
        longint vx, vy, ang, big, xs, ys, r;
        if (dx == 0 && dy == 0) return '0;
        vx = dx;
        vy = dy;
        ang = 0;
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            ang = (dy >= 0) ? PI_Q24 : -PI_Q24;
        end
        big = (vx > (vy < 0 ? -vy : vy)) ? vx : (vy < 0 ? -vy : vy);
        while (big < (64'sd1 <<< NORM_BIT)) begin
            vx = vx * 2;
            vy = vy * 2;
            big = big * 2;
        end
        for (int i = 0; i < 20; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx = vx + ys;
                vy = vy - xs;
                ang = ang + ARCTAN[i];
            end
            else begin
                vx = vx - ys;
                vy = vy + xs;
                ang = ang - ARCTAN[i];
            end
        end
        r = (ang + 1024) >>> 11;
        if (r > HEAD_MAX) r = HEAD_MAX;
        if (r < -HEAD_MAX) r = -HEAD_MAX;
        return r[15:0];
    endfunction

    // Search the segments for the query time and update the held pose.
    function automatic pose_word_t evaluate_query(input logic [31:0] qt);
        int     nseg, deg, base;
        longint t, s, e, span, u;
        bit     hit;
        pose_word_t w;
        nseg = (seg_reg > SEGS) ? SEGS : seg_reg;
        deg  = (deg_reg > DEG_MAX) ? DEG_MAX : deg_reg;
        t    = longint'(qt);
        hit  = 0;
        for (int i = 0; i < nseg && !hit; i++) begin
            s = knot_store[i];
            e = knot_store[i+1];
            if (t >= s && t <= e) begin
                span = e - s;
                u = (span == 0) ? 0 : ((t - s) * 65536) / span;
                base = i * (DEG_MAX + 1);
                held_pose.x  = 32'(sat_word(position_at(AX_X, base, deg, u)));
                held_pose.y  = 32'(sat_word(position_at(AX_Y, base, deg, u)));
                held_pose.z  = 32'(sat_word(position_at(AX_Z, base, deg, u)));
                held_pose.hd = yaw_of(slope_at(AX_X, base, deg, u),
                                      slope_at(AX_Y, base, deg, u));
                hit = 1;
            end
        end
        w = held_pose;
        w.fnd = hit;
        return w;
    endfunction

    assign pending = wr_count - rd_count;

    // Inputs and outputs change only at the rising edge, so the values seen
    // at the falling edge are those the next rising edge accepts.
    always @(negedge clk or negedge rst_n) begin
        pose_word_t want;
        if (!rst_n) begin
            seg_reg    <= 5'd1;
            deg_reg    <= 3'd7;
            held_pose  <= '0;
            fail_count <= 0;
            mismatches = 0;
            wr_count   = 0;
            rd_count   = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SEGMENTS) seg_reg = cfg_data[4:0];
                else if (cfg_index == CFG_DEGREE) deg_reg = cfg_data[2:0];
            end
            if (in_valid && in_ready) begin
                case (operation)
                    OP_KNOT: if (entry_index < KNOTS) knot_store[entry_index] = entry_value;
                    OP_COEF: if (axis != AXIS_NONE) coef_store[axis][entry_index] = entry_value;
                    OP_EVAL: begin
                        expected_poses[wr_count % DEPTH] = evaluate_query(query_time);
                        wr_count++;
                    end
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (wr_count == rd_count) begin
                    mismatches++;
                    fail_count <= mismatches;
                    if (mismatches <= 10)
                        $display("ERROR: result word with none expected: x=%0d y=%0d z=%0d",
                                 pose_x, pose_y, pose_z);
                end
                else begin
                    want = expected_poses[rd_count % DEPTH];
                    rd_count++;
                    if (want.x !== pose_x || want.y !== pose_y || want.z !== pose_z ||
                        want.hd !== heading || want.fnd !== found) begin
                        mismatches++;
                        fail_count <= mismatches;
                        if (mismatches <= 10)
                            $display("ERROR: pose mismatch: expected x=%0d y=%0d z=%0d hd=%0d f=%0d, got x=%0d y=%0d z=%0d hd=%0d f=%0d",
                                     want.x, want.y, want.z, want.hd, want.fnd,
                                     pose_x, pose_y, pose_z, heading, found);
                    end
                end
            end
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the pose evaluator with a fill of the live stores, a short directed
// set (segment ends, no-match, zero span, heading extremes, ignored words)
// and random load-and-query sequences under several register settings and
// sender/receiver idling mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import ppe_pkg::*;

    localparam int          LIMIT      = 1000000;
    localparam int          SETTLE     = 160;
    // Only the first segments carry coefficients; the knots past them are
    // parked at the most negative time so no query can land there.
    localparam int          LIVE_SEGS  = 8;
    localparam logic [31:0] KNOT_OFF   = 32'h80000000;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam logic [1:0]  AXIS_X     = 2'd0;
    localparam logic [1:0]  AXIS_Y     = 2'd1;
    localparam logic [1:0]  AXIS_Z     = 2'd2;
    localparam logic [1:0]  AXIS_NONE  = 2'd3;
    localparam logic [1:0]  CFG_SPARE  = 2'd2;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         operation = '0;
    logic [6:0]         entry_index = '0;
    logic [1:0]         axis = '0;
    logic signed [31:0] entry_value = '0;
    logic [31:0]        query_time = '0;
    logic               out_valid;
    logic               out_ready = 1'b1;
    logic signed [31:0] pose_x, pose_y, pose_z;
    logic signed [15:0] heading;
    logic               found;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 in_idle = 0;
    int                 out_idle = 0;
    int                 cycles = 0;
    int                 seg_now = 1;
    int                 deg_now = 7;
    logic signed [31:0] knot_copy [17];

    piecewise_poly_pose_eval u_top (.*);

    ppe_checker u_chk (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= out_idle);
    end

    initial begin
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("piecewise_poly_pose_eval test failed");
                $finish;
            end
        end
    end

    // Present one input word and return at the edge that accepts it.
    task automatic send_word(input logic [1:0] op, input logic [6:0] idx,
                             input logic [1:0] ax, input logic [31:0] val,
                             input logic [31:0] qt);
        if ($urandom_range(99) < in_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < in_idle);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        axis        <= ax;
        entry_value <= val;
        query_time  <= qt;
        if (op == OP_KNOT && idx < 17) knot_copy[idx] = val;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    // Let every outstanding result and any load in flight finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write; only called with the block drained.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SEGMENTS) seg_now = int'(data[4:0]);
        else if (idx == CFG_DEGREE) deg_now = int'(data[2:0]);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(1, 0) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(262143)) - 131072);
        endcase
    endfunction

    // One well-formed sequence: non-decreasing knots, a few coefficients, queries.
    task automatic run_sequence(inout int words);
        int n, nq;
        logic [31:0] t, lo, hi;
        n = (seg_now > LIVE_SEGS) ? LIVE_SEGS : seg_now;
        if (n == 0) n = 1;
        t = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(4) * 65536;
        for (int k = 0; k <= n; k++) begin
            send_word(OP_KNOT, 7'(k), AXIS_X, t, $urandom());
            words++;
            if ($urandom_range(9) != 0) t = t + $urandom_range(1, 8 * 65536);
        end
        repeat ($urandom_range(2, 8)) begin
            send_word(OP_COEF, 7'($urandom_range(n * 8 - 1)), 2'($urandom_range(2)),
                      pick_coef(), $urandom());
            words++;
        end
        nq = $urandom_range(3, 8);
        lo = knot_copy[0];
        hi = knot_copy[n];
        repeat (nq) begin
            case ($urandom_range(9))
                0:       t = $urandom();
                1:       t = knot_copy[$urandom_range(n)];
                default: t = $urandom_range(hi, lo);
            endcase
            send_word(OP_EVAL, 7'($urandom()), 2'($urandom()), $urandom(), t);
            words++;
        end
        // Noise: ignored words and stray loads.
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
                0: send_word(OP_UNUSED, 7'($urandom()), 2'($urandom()), $urandom(), $urandom());
                1: send_word(OP_KNOT, 7'($urandom_range(127, 17)), 2'($urandom()),
                             $urandom(), $urandom());
                default: send_word(OP_COEF, 7'($urandom()), AXIS_NONE, $urandom(), $urandom());
            endcase
        end
    endtask

    initial begin
        int words;
        int mixes [3][2];
        int settings [8][2];
        mixes = '{'{28, 64}, '{64, 28}, '{0, 0}};
        settings = '{'{16, 7}, '{1, 1}, '{0, 3}, '{31, 0}, '{5, 7},
                     '{8, 2}, '{17, 5}, '{3, 4}};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every knot and the live coefficients so no query reads an
        // unwritten entry.
        for (int k = 0; k < 17; k++)
            send_word(OP_KNOT, 7'(k), AXIS_X,
                      (k <= LIVE_SEGS) ? 32'(k * 65536) : KNOT_OFF, 32'd0);
        for (int a = 0; a < 3; a++)
            for (int c = 0; c < LIVE_SEGS * 8; c++)
                send_word(OP_COEF, 7'(c), 2'(a), pick_coef(), 32'd0);

        // Directed: segment ends, no match, ignored words, zero span.
        send_word(OP_EVAL, 7'd0, AXIS_X, 32'd0, 32'd0);
        send_word(OP_EVAL, 7'd0, AXIS_X, 32'd0, 32'd65536);
        send_word(OP_EVAL, 7'h7F, AXIS_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(OP_KNOT, 7'h7F, AXIS_NONE, 32'h12345678, 32'd0);
        send_word(OP_COEF, 7'h7F, AXIS_NONE, 32'h7FFFFFFF, 32'd0);
        send_word(OP_UNUSED, 7'h7F, AXIS_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(OP_KNOT, 7'd1, AXIS_X, 32'd0, 32'd0);
        send_word(OP_EVAL, 7'd0, AXIS_X, 32'd0, 32'd0);
        send_word(OP_KNOT, 7'd1, AXIS_X, 32'd65536, 32'd0);
        drain();
        write_reg(CFG_DEGREE, 32'd1);

        // Directed: heading of pi, zero derivative, saturated positions.
        send_word(OP_COEF, 7'd1, AXIS_X, 32'hFFFF0000, 32'd0);
        send_word(OP_COEF, 7'd1, AXIS_Y, 32'd0, 32'd0);
        send_word(OP_EVAL, 7'd0, AXIS_X, 32'd0, 32'd32768);
        send_word(OP_COEF, 7'd1, AXIS_X, 32'd0, 32'd0);
        send_word(OP_EVAL, 7'd0, AXIS_X, 32'd0, 32'd32768);
        send_word(OP_COEF, 7'd0, AXIS_X, 32'h7FFFFFFF, 32'd0);
        send_word(OP_COEF, 7'd1, AXIS_X, 32'h7FFFFFFF, 32'd0);
        send_word(OP_COEF, 7'd0, AXIS_Z, 32'h80000000, 32'd0);
        send_word(OP_COEF, 7'd1, AXIS_Z, 32'h80000000, 32'd0);
        send_word(OP_EVAL, 7'd0, AXIS_X, 32'd0, 32'd65536);
        drain();
        write_reg(CFG_SPARE, $urandom());

        // Random sequences under each idling mix and several settings.
        for (int p = 0; p < 3; p++) begin
            in_idle  = mixes[p][0];
            out_idle = mixes[p][1];
            for (int s = 0; s < 3; s++) begin
                drain();
                if (p * 3 + s < 8) begin
                    write_reg(CFG_SEGMENTS, 32'(settings[p * 3 + s][0]));
                    write_reg(CFG_DEGREE, 32'(settings[p * 3 + s][1]));
                end
                else begin
                    write_reg(CFG_SEGMENTS, $urandom());
                    write_reg(CFG_DEGREE, $urandom());
                end
                words = 0;
                while (words < 16) begin
                    run_sequence(words);
                    // Hold off now and then until all results are back.
                    if ($urandom_range(7) == 0) begin
                        in_valid <= 1'b0;
                        while (pending != 0) @(posedge clk);
                    end
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("piecewise_poly_pose_eval test passed");
        end
        else begin
            $display("piecewise_poly_pose_eval test failed");
        end
        $finish;
    end

endmodule
